@@ rtl/core/elfr_pkg.sv @@
// Shared types and constants for the escaped length frame receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package elfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE_CODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPED_ESCAPE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_CAPACITY = 2'd2;

  localparam logic [ByteW-1:0] EscapeCodeRst      = 8'd219;
  localparam logic [ByteW-1:0] EscapedEscapeRst   = 8'd221;
  localparam logic [LenW-1:0]  BufferCapacityRst  = 16'd256;

  typedef struct packed {
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] escaped_escape_code;
    logic [LenW-1:0]  buffer_capacity;
  } elfr_cfg_t;

  typedef struct packed {
    logic             write_valid;
    logic [LenW-1:0]  write_index;
    logic [ByteW-1:0] write_data;
    logic             frame_ready;
    logic [LenW-1:0]  frame_length;
    logic             overflow_abort;
  } elfr_result_t;

endpackage

`default_nettype wire

@@ rtl/core/elfr_in_stage.sv @@
// Input register of the receiver: holds one raw byte until the decoder takes it.
// Depends on elfr_pkg.
`default_nettype none

module elfr_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [elfr_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                      advance_i,
  output logic                           valid_o,
  output logic [elfr_pkg::ByteW-1:0]     byte_o
);
  import elfr_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;
  logic             load;

  // the register empties into the decoder whenever the output side moves
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

@@ rtl/core/elfr_decoder.sv @@
// Frame state machine: unescapes a byte, tracks length and index, forms the result.
// Depends on elfr_pkg.
`default_nettype none

module elfr_decoder (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic [elfr_pkg::ByteW-1:0] byte_i,
  input  wire elfr_pkg::elfr_cfg_t       cfg_i,
  output elfr_pkg::elfr_result_t         result_o
);
  import elfr_pkg::*;

  localparam logic [2:0] MODE_LEN_LO = 3'd0;
  localparam logic [2:0] MODE_LEN_HI = 3'd1;
  localparam logic [2:0] MODE_DATA   = 3'd2;
  localparam logic [2:0] MODE_ESC    = 3'd3;
  localparam logic [2:0] MODE_DONE   = 3'd4;

  logic [2:0]      mode_q, mode_d;
  logic [2:0]      ret_q, ret_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;

  logic [2:0]       eff_mode;
  logic [ByteW-1:0] val;
  logic [LenW-1:0]  idx_inc;

  assign idx_inc = idx_q + 16'd1;

  always_comb begin
    mode_d   = mode_q;
    ret_d    = ret_q;
    len_d    = len_q;
    idx_d    = idx_q;
    eff_mode = mode_q;
    val      = byte_i;
    result_o = '0;

    if (byte_i == '0) begin
      mode_d = MODE_LEN_LO;
      ret_d  = MODE_LEN_LO;
      len_d  = '0;
    end else if (byte_i == cfg_i.escape_code) begin
      // a second escape saves the escape mode itself: locked until a zero byte
      ret_d  = mode_q;
      mode_d = MODE_ESC;
    end else begin
      if (mode_q == MODE_ESC) begin
        val      = (byte_i == cfg_i.escaped_escape_code) ? cfg_i.escape_code : '0;
        eff_mode = ret_q;
      end
      mode_d = eff_mode;
      unique case (eff_mode)
        MODE_LEN_LO: begin
          len_d  = {{(LenW-ByteW){1'b0}}, val};
          mode_d = MODE_LEN_HI;
        end
        MODE_LEN_HI: begin
          len_d  = {val, len_q[ByteW-1:0]};
          mode_d = MODE_DATA;
          idx_d  = '0;
        end
        MODE_DATA: begin
          if (idx_q >= cfg_i.buffer_capacity) begin
            mode_d                  = MODE_LEN_LO;
            ret_d                   = MODE_LEN_LO;
            len_d                   = '0;
            result_o.overflow_abort = 1'b1;
          end else begin
            result_o.write_valid = 1'b1;
            result_o.write_index = idx_q;
            result_o.write_data  = val;
            idx_d                = idx_inc;
            // abort wins over completion
            if (idx_inc >= cfg_i.buffer_capacity) begin
              mode_d                  = MODE_LEN_LO;
              ret_d                   = MODE_LEN_LO;
              len_d                   = '0;
              result_o.overflow_abort = 1'b1;
            end else if (idx_inc >= len_q) begin
              mode_d = MODE_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end

    result_o.frame_ready  = (mode_d == MODE_DONE);
    result_o.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LEN_LO;
      ret_q  <= MODE_LEN_LO;
      len_q  <= '0;
      idx_q  <= '0;
    end else if (step_i) begin
      mode_q <= mode_d;
      ret_q  <= ret_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/elfr_out_stage.sv @@
// Result register: holds one result word until the downstream side takes it.
// Depends on elfr_pkg.
`default_nettype none

module elfr_out_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire elfr_pkg::elfr_result_t result_i,
  output logic                       advance_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output elfr_pkg::elfr_result_t     result_o
);
  import elfr_pkg::*;

  logic         valid_q;
  elfr_result_t result_q;

  // register is free when empty or being taken this cycle
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

@@ rtl/core/escaped_length_frame_receiver_core.sv @@
// Byte-stuffed, length-prefixed deframer. One raw byte is taken per cycle while the
// output is not stalled, and one result word leaves per byte (input register, then
// result register); the rate is one byte per cycle, set by the combinational
// update of the frame state between the two registers. A zero byte always
// resynchronises; the escape byte is configurable, and the first two decoded
// bytes give the frame length, low byte first. Configuration writes are taken at
// any time (ready is always high) but are meant for an idle block.
// Depends on elfr_pkg, elfr_in_stage, elfr_decoder, elfr_out_stage.
`default_nettype none

module escaped_length_frame_receiver_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // byte input
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [elfr_pkg::ByteW-1:0]   in_byte_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              write_valid_o,
  output logic [elfr_pkg::LenW-1:0]         write_index_o,
  output logic [elfr_pkg::ByteW-1:0]        write_data_o,
  output logic                              frame_ready_o,
  output logic [elfr_pkg::LenW-1:0]         frame_length_o,
  output logic                              overflow_abort_o,
  // configuration
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [elfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [elfr_pkg::LenW-1:0]    cfg_data_i
);
  import elfr_pkg::*;

  elfr_cfg_t        cfg_q;
  logic             advance;
  logic             stage_valid;
  logic [ByteW-1:0] stage_byte;
  elfr_result_t     step_result;
  elfr_result_t     out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_code         <= EscapeCodeRst;
      cfg_q.escaped_escape_code <= EscapedEscapeRst;
      cfg_q.buffer_capacity     <= BufferCapacityRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ESCAPE_CODE:     cfg_q.escape_code         <= cfg_data_i[ByteW-1:0];
        CFG_ESCAPED_ESCAPE:  cfg_q.escaped_escape_code <= cfg_data_i[ByteW-1:0];
        CFG_BUFFER_CAPACITY: cfg_q.buffer_capacity     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  elfr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  elfr_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (stage_valid && advance),
    .byte_i   (stage_byte),
    .cfg_i    (cfg_q),
    .result_o (step_result)
  );

  elfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .result_i    (step_result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign write_valid_o    = out_result.write_valid;
  assign write_index_o    = out_result.write_index;
  assign write_data_o     = out_result.write_data;
  assign frame_ready_o    = out_result.frame_ready;
  assign frame_length_o   = out_result.frame_length;
  assign overflow_abort_o = out_result.overflow_abort;

endmodule

`default_nettype wire

@@ rtl/core/elfr_checker.sv @@
// Port-level checks for escaped_length_frame_receiver_core, bound to the top level.
// Depends on elfr_pkg and the top level's port list.
`default_nettype none

module elfr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         write_valid_o,
  input wire logic [elfr_pkg::LenW-1:0]    write_index_o,
  input wire logic [elfr_pkg::ByteW-1:0]   write_data_o,
  input wire logic                         frame_ready_o,
  input wire logic [elfr_pkg::LenW-1:0]    frame_length_o,
  input wire logic                         overflow_abort_o
);
  import elfr_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(write_valid_o)
      && $stable(write_index_o) && $stable(write_data_o) && $stable(frame_ready_o)
      && $stable(frame_length_o) && $stable(overflow_abort_o))
    else $error("result word changed while stalled");

  // an aborted frame leaves the receiver waiting for a new length
  a_abort_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_abort_o |-> !frame_ready_o && frame_length_o == '0)
    else $error("abort did not drop the frame");

  a_idle_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_index_o == '0 && write_data_o == '0)
    else $error("write fields not zero without a write");

  // completion on a written byte only once its index plus one reaches the length
  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o && frame_ready_o
      |-> ({1'b0, write_index_o} + 17'd1) >= {1'b0, frame_length_o})
    else $error("frame completed before its length");

endmodule

bind escaped_length_frame_receiver_core elfr_checker u_elfr_checker (.*);

`default_nettype wire
